[rtl/slx_pkg.sv]
// shared types and constants of the specification language lexer
package slx_pkg;

	localparam int KW_BYTES  = 9;
	localparam int TOK_CNT_W = 7;
	localparam int KW_COUNT  = 30;
	localparam int QDEPTH    = 2;

	localparam logic [5:0] KIND_IDENT   = 6'd0;
	localparam logic [5:0] KIND_LBRACK  = 6'd1;
	localparam logic [5:0] KIND_RBRACK  = 6'd2;
	localparam logic [5:0] KIND_LBRACE  = 6'd3;
	localparam logic [5:0] KIND_RBRACE  = 6'd4;
	localparam logic [5:0] KIND_LPAREN  = 6'd5;
	localparam logic [5:0] KIND_RPAREN  = 6'd6;
	localparam logic [5:0] KIND_COMMA   = 6'd7;
	localparam logic [5:0] KIND_SEMI    = 6'd8;
	localparam logic [5:0] KIND_COLON   = 6'd9;
	localparam logic [5:0] KIND_EQ      = 6'd10;
	localparam logic [5:0] KIND_IMPLIES = 6'd11;
	localparam logic [5:0] KIND_LT      = 6'd12;
	localparam logic [5:0] KIND_LE      = 6'd13;
	localparam logic [5:0] KIND_GT      = 6'd14;
	localparam logic [5:0] KIND_GE      = 6'd15;
	localparam logic [5:0] KIND_DOT     = 6'd16;
	localparam logic [5:0] KIND_DOTTIL  = 6'd17;
	localparam logic [5:0] KIND_BAR     = 6'd18;
	localparam logic [5:0] KIND_BANG    = 6'd19;
	localparam logic [5:0] KIND_MINUS   = 6'd20;
	localparam logic [5:0] KIND_ARROW   = 6'd21;
	localparam logic [5:0] KIND_PLUS    = 6'd22;
	localparam logic [5:0] KIND_STAR    = 6'd23;
	localparam logic [5:0] KIND_DIV     = 6'd24;
	localparam logic [5:0] KIND_EOL     = 6'd25;
	localparam logic [5:0] KIND_EOF     = 6'd26;
	localparam logic [5:0] KIND_KW_BASE = 6'd27;
	localparam logic [5:0] KIND_ERROR   = 6'd57;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0a;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_COLON  = 8'h3a;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_LT     = 8'h3c;
	localparam logic [7:0] CH_EQ     = 8'h3d;
	localparam logic [7:0] CH_GT     = 8'h3e;
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_RBRACK = 8'h5d;
	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_BAR    = 8'h7c;
	localparam logic [7:0] CH_RBRACE = 8'h7d;
	localparam logic [7:0] CH_TILDE  = 8'h7e;

	typedef struct packed {
		logic                       is_word;
		logic [5:0]                 kind;
		logic [TOK_CNT_W-1:0]       cnt;
		logic                       ovf;
		logic [KW_BYTES-1:0][7:0]   text;
	} tok_t;

	typedef struct packed {
		logic two;
		tok_t t1;
		tok_t t0;
	} rec_t;

endpackage

[rtl/spec_language_lexer.sv]
// top level of the specification language lexer
// usage:
//   input channel: in_valid/in_ready carry one word per item, a character on
//   char_in or an end-of-input mark on end_of_input.
//   output channel: out_valid/out_ready carry one token per word with kind,
//   length, first eight text bytes, overflow flag and last.
//   an input word causes zero, one or two tokens; last marks the final one.
// path: a token passes through the record queue and then the output register.
// throughput: one input word per cycle while the queue is not full and each
//   causes at most one token; a word that causes two tokens holds the back end
//   until both are sent. the front end updates lexer state on each accepted
//   word, a two-entry record queue separates it from the back end, where keyword lookup is combinational.
// reset: clears lexer mode, word count, queue and output valid; no clearing
//   pass, the block is ready as soon as reset is released.
// stall: when out_ready is low the output holds, the queue fills, then
//   in_ready drops until the back end drains.
module spec_language_lexer import slx_pkg::*; #(
	parameter int LEXEME_MAX = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_in,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  token_kind,
	output logic [4:0]  lexeme_length,
	output logic [63:0] lexeme_text,
	output logic        lexeme_overflow,
	output logic        last
);

	logic push, full, pop, empty;
	rec_t push_rec, head;

	slx_front #(.LEXEME_MAX(LEXEME_MAX)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_in      (char_in),
		.end_of_input (end_of_input),
		.q_full       (full),
		.push         (push),
		.push_rec     (push_rec)
	);

	slx_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	slx_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.empty           (empty),
		.head            (head),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.token_kind      (token_kind),
		.lexeme_length   (lexeme_length),
		.lexeme_text     (lexeme_text),
		.lexeme_overflow (lexeme_overflow),
		.last            (last)
	);

endmodule

[rtl/slx_front.sv]
// front end: takes characters, tracks lexer state and builds token records
module slx_front import slx_pkg::*; #(
	parameter int LEXEME_MAX = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_in,
	input  logic       end_of_input,
	input  logic       q_full,
	output logic       push,
	output rec_t       push_rec
);

	localparam int CW = $clog2(LEXEME_MAX + 1);

	localparam logic [2:0] M_IDLE      = 3'd0;
	localparam logic [2:0] M_PAIR      = 3'd1;
	localparam logic [2:0] M_SLASH     = 3'd2;
	localparam logic [2:0] M_WORD      = 3'd3;
	localparam logic [2:0] M_WORD_OPEN = 3'd4;
	localparam logic [2:0] M_COMMENT   = 3'd5;
	localparam logic [2:0] M_STAR      = 3'd6;
	localparam logic [2:0] M_SKIP      = 3'd7;

	typedef struct packed {
		logic       hit;
		logic [7:0] second;
		logic [5:0] one;
		logic [5:0] two;
	} pair_t;

	logic [2:0]               mode_q, w_mode;
	logic [CW-1:0]            cnt_q, w_cnt;
	logic                     ovf_q, w_ovf;
	logic [KW_BYTES-1:0][7:0] st_q, w_st;
	tok_t                     tq [2];
	logic [1:0]               n;
	logic                     go_word, go_idle, accept, eoi, blank;
	pair_t                    pi, pc;
	logic [7:0]               c;

	function automatic logic is_sep(input logic [7:0] x);
		case (x)
			CH_SPACE, CH_BAR, CH_MINUS, CH_PLUS, CH_STAR, CH_SLASH, CH_RBRACK,
			CH_RPAREN, CH_SEMI, CH_COLON, CH_RBRACE, CH_LBRACK, CH_LPAREN,
			CH_LBRACE, CH_LT, CH_EQ, CH_NL, CH_GT, CH_DOT, CH_COMMA: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// zero means no single punctuation
	function automatic logic [5:0] single_kind(input logic [7:0] x);
		case (x)
			CH_LBRACK: return KIND_LBRACK;
			CH_RBRACK: return KIND_RBRACK;
			CH_LBRACE: return KIND_LBRACE;
			CH_RBRACE: return KIND_RBRACE;
			CH_LPAREN: return KIND_LPAREN;
			CH_RPAREN: return KIND_RPAREN;
			CH_COMMA:  return KIND_COMMA;
			CH_SEMI:   return KIND_SEMI;
			CH_COLON:  return KIND_COLON;
			CH_BAR:    return KIND_BAR;
			CH_BANG:   return KIND_BANG;
			CH_PLUS:   return KIND_PLUS;
			CH_STAR:   return KIND_STAR;
			CH_NL:     return KIND_EOL;
			default:   return KIND_IDENT;
		endcase
	endfunction

	function automatic pair_t pair_info(input logic [7:0] x);
		pair_t p;
		p = '0;
		case (x)
			CH_EQ:    p = '{1'b1, CH_GT, KIND_EQ, KIND_IMPLIES};
			CH_LT:    p = '{1'b1, CH_EQ, KIND_LT, KIND_LE};
			CH_GT:    p = '{1'b1, CH_EQ, KIND_GT, KIND_GE};
			CH_DOT:   p = '{1'b1, CH_TILDE, KIND_DOT, KIND_DOTTIL};
			CH_MINUS: p = '{1'b1, CH_GT, KIND_MINUS, KIND_ARROW};
			default:  p = '0;
		endcase
		return p;
	endfunction

	function automatic tok_t mk_simple(input logic [5:0] k, input logic [1:0] len,
		input logic [7:0] b0, input logic [7:0] b1);
		tok_t t;
		t = '0;
		t.kind = k;
		t.cnt = TOK_CNT_W'(len);
		t.text[0] = b0;
		t.text[1] = b1;
		return t;
	endfunction

	assign c        = char_in;
	assign eoi      = end_of_input;
	assign blank    = (c == CH_SPACE) || (c == CH_TAB);
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign pi       = pair_info(st_q[0]);
	assign pc       = pair_info(c);

	always_comb begin
		w_mode  = mode_q;
		w_cnt   = cnt_q;
		w_ovf   = ovf_q;
		w_st    = st_q;
		n       = 2'd0;
		tq[0]   = '0;
		tq[1]   = '0;
		go_word = 1'b0;
		go_idle = 1'b0;
		case (mode_q)
			M_IDLE: go_idle = 1'b1;
			M_PAIR: begin
				w_cnt  = '0;
				w_mode = M_IDLE;
				if (!eoi && c == pi.second) begin
					tq[n[0]] = mk_simple(pi.two, 2'd2, st_q[0], c);
					n = n + 2'd1;
				end else begin
					tq[n[0]] = mk_simple(pi.one, 2'd1, st_q[0], 8'h00);
					n = n + 2'd1;
					go_idle = 1'b1;
				end
			end
			M_SLASH: begin
				if (!eoi && c == CH_STAR) begin
					w_mode = M_COMMENT;
				end else if (w_cnt == '0) begin
					tq[n[0]] = mk_simple(KIND_DIV, 2'd1, CH_SLASH, 8'h00);
					n = n + 2'd1;
					w_mode = M_IDLE;
					go_idle = 1'b1;
				end else begin
					if (w_cnt < CW'(LEXEME_MAX)) begin
						for (int j = 0; j < KW_BYTES; j++)
							if (w_cnt == CW'(j)) w_st[j] = CH_SLASH;
						w_cnt = w_cnt + 1'b1;
					end else begin
						w_ovf = 1'b1;
					end
					w_mode = M_WORD;
					go_word = 1'b1;
				end
			end
			M_WORD: go_word = 1'b1;
			M_WORD_OPEN: begin
				if (eoi) begin
					tq[0] = '{1'b1, KIND_IDENT, TOK_CNT_W'(w_cnt), w_ovf, w_st};
					tq[1] = mk_simple(KIND_EOF, 2'd0, 8'h00, 8'h00);
					n = 2'd2;
					w_cnt = '0;
					w_ovf = 1'b0;
					w_mode = M_IDLE;
				end else if (blank) begin
					w_mode = M_WORD_OPEN;
				end else if (c == CH_SLASH) begin
					w_mode = M_SLASH;
				end else begin
					if (w_cnt < CW'(LEXEME_MAX)) begin
						for (int j = 0; j < KW_BYTES; j++)
							if (w_cnt == CW'(j)) w_st[j] = c;
						w_cnt = w_cnt + 1'b1;
					end else begin
						w_ovf = 1'b1;
					end
					w_mode = M_WORD;
				end
			end
			M_COMMENT, M_STAR: begin
				if (eoi) begin
					tq[0] = mk_simple(KIND_ERROR, 2'd0, 8'h00, 8'h00);
					tq[1] = mk_simple(KIND_EOF, 2'd0, 8'h00, 8'h00);
					n = 2'd2;
					w_cnt = '0;
					w_ovf = 1'b0;
					w_mode = M_IDLE;
				end else if (c == CH_STAR) begin
					w_mode = M_STAR;
				end else if (c == CH_SLASH && mode_q == M_STAR) begin
					w_mode = M_SKIP;
				end else if (c != CH_SLASH) begin
					w_mode = M_COMMENT;
				end
			end
			default: begin
				// character after comment close is dropped
				if (eoi) begin
					if (w_cnt != '0) begin
						tq[0] = '{1'b1, KIND_IDENT, TOK_CNT_W'(w_cnt), w_ovf, w_st};
						tq[1] = mk_simple(KIND_EOF, 2'd0, 8'h00, 8'h00);
						n = 2'd2;
						w_cnt = '0;
						w_ovf = 1'b0;
					end else begin
						tq[0] = mk_simple(KIND_EOF, 2'd0, 8'h00, 8'h00);
						n = 2'd1;
					end
					w_mode = M_IDLE;
				end else begin
					w_mode = (w_cnt != '0) ? M_WORD_OPEN : M_IDLE;
				end
			end
		endcase

		if (go_word) begin
			if (eoi) begin
				tq[n[0]] = '{1'b1, KIND_IDENT, TOK_CNT_W'(w_cnt), w_ovf, w_st};
				n = n + 2'd1;
				tq[n[0]] = mk_simple(KIND_EOF, 2'd0, 8'h00, 8'h00);
				n = n + 2'd1;
				w_cnt = '0;
				w_ovf = 1'b0;
				w_mode = M_IDLE;
			end else if (is_sep(c)) begin
				tq[n[0]] = '{1'b1, KIND_IDENT, TOK_CNT_W'(w_cnt), w_ovf, w_st};
				n = n + 2'd1;
				w_cnt = '0;
				w_ovf = 1'b0;
				w_mode = M_IDLE;
				go_idle = 1'b1;
			end else if (c == CH_TAB) begin
				w_mode = M_WORD_OPEN;
			end else begin
				if (w_cnt < CW'(LEXEME_MAX)) begin
					for (int j = 0; j < KW_BYTES; j++)
						if (w_cnt == CW'(j)) w_st[j] = c;
					w_cnt = w_cnt + 1'b1;
				end else begin
					w_ovf = 1'b1;
				end
			end
		end

		if (go_idle) begin
			if (eoi) begin
				tq[n[0]] = mk_simple(KIND_EOF, 2'd0, 8'h00, 8'h00);
				n = n + 2'd1;
			end else if (blank) begin
				w_mode = M_IDLE;
			end else if (c == CH_SLASH) begin
				w_cnt = '0;
				w_mode = M_SLASH;
			end else if (pc.hit) begin
				w_st[0] = c;
				w_cnt = CW'(1);
				w_mode = M_PAIR;
			end else if (single_kind(c) != KIND_IDENT) begin
				tq[n[0]] = mk_simple(single_kind(c), 2'd1, c, 8'h00);
				n = n + 2'd1;
			end else begin
				w_st[0] = c;
				w_cnt = CW'(1);
				w_ovf = 1'b0;
				w_mode = M_WORD;
			end
		end
	end

	assign push        = accept && (n != 2'd0);
	assign push_rec.two = (n == 2'd2);
	assign push_rec.t0  = tq[0];
	assign push_rec.t1  = tq[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (accept) begin
			mode_q <= w_mode;
			cnt_q  <= w_cnt;
			ovf_q  <= w_ovf;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			st_q <= w_st;
		end
	end

endmodule

[rtl/slx_fifo.sv]
// short record queue between front and back end
module slx_fifo import slx_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t push_rec,
	output logic full,
	input  logic pop,
	output logic empty,
	output rec_t head
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int NW = $clog2(QDEPTH + 1);

	rec_t          mem_q [QDEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [NW-1:0] num_q;

	assign full  = (num_q == NW'(QDEPTH));
	assign empty = (num_q == '0);
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			num_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PW'(QDEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == PW'(QDEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (push && !pop)      num_q <= num_q + 1'b1;
			else if (pop && !push) num_q <= num_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_rec;
	end

endmodule

[rtl/slx_back.sv]
// back end: keyword lookup, text masking and the output register
module slx_back import slx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        empty,
	input  rec_t        head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  token_kind,
	output logic [4:0]  lexeme_length,
	output logic [63:0] lexeme_text,
	output logic        lexeme_overflow,
	output logic        last
);

	function automatic logic [8*KW_BYTES-1:0] kw_str(input int i);
		case (i)
			0:  return (8*KW_BYTES)'("in");
			1:  return (8*KW_BYTES)'("isvalid");
			2:  return (8*KW_BYTES)'("and");
			3:  return (8*KW_BYTES)'("or");
			4:  return (8*KW_BYTES)'("crash");
			5:  return (8*KW_BYTES)'("cast");
			6:  return (8*KW_BYTES)'("NULL");
			7:  return (8*KW_BYTES)'("partition");
			8:  return (8*KW_BYTES)'("many");
			9:  return (8*KW_BYTES)'("set");
			10: return (8*KW_BYTES)'("structure");
			11: return (8*KW_BYTES)'("reserved");
			12: return (8*KW_BYTES)'("label");
			13: return (8*KW_BYTES)'("int");
			14: return (8*KW_BYTES)'("short");
			15: return (8*KW_BYTES)'("bit");
			16: return (8*KW_BYTES)'("byte");
			17: return (8*KW_BYTES)'("subtype");
			18: return (8*KW_BYTES)'("of");
			19: return (8*KW_BYTES)'("element");
			20: return (8*KW_BYTES)'("forall");
			21: return (8*KW_BYTES)'("for");
			22: return (8*KW_BYTES)'("sizeof");
			23: return (8*KW_BYTES)'("literal");
			24: return (8*KW_BYTES)'("param");
			25: return (8*KW_BYTES)'("1");
			26: return (8*KW_BYTES)'("true");
			27: return (8*KW_BYTES)'("to");
			28: return (8*KW_BYTES)'("delay");
			29: return (8*KW_BYTES)'("static");
			default: return '0;
		endcase
	endfunction

	function automatic int kw_len(input int i);
		case (i)
			25: return 1;
			0, 3, 18, 27: return 2;
			2, 9, 13, 15, 21: return 3;
			5, 6, 8, 16, 26: return 4;
			4, 12, 14, 24, 28: return 5;
			20, 22, 29: return 6;
			1, 17, 19, 23: return 7;
			11: return 8;
			default: return 9;
		endcase
	endfunction

	function automatic logic [5:0] kw_kind(input logic [KW_BYTES-1:0][7:0] st,
		input logic [TOK_CNT_W-1:0] cnt);
		logic [5:0]           k;
		logic                 hit;
		logic [8*KW_BYTES-1:0] s;
		int                   l;
		k = KIND_IDENT;
		for (int i = 0; i < KW_COUNT; i++) begin
			s = kw_str(i);
			l = kw_len(i);
			hit = (cnt == TOK_CNT_W'(l));
			for (int j = 0; j < KW_BYTES; j++)
				if (j < l && st[j] != s[8*(l-1-j) +: 8]) hit = 1'b0;
			if (hit) k = KIND_KW_BASE + 6'(i);
		end
		return k;
	endfunction

	logic       idx_q;
	logic       load, fin;
	tok_t       t;
	logic [5:0] k;

	assign t    = idx_q ? head.t1 : head.t0;
	assign fin  = idx_q || !head.two;
	assign load = !empty && (!out_valid || out_ready);
	assign pop  = load && fin;
	assign k    = (t.is_word && !t.ovf) ? kw_kind(t.text, t.cnt) : t.kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			idx_q     <= 1'b0;
		end else begin
			if (load) begin
				out_valid <= 1'b1;
				idx_q     <= !fin;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			token_kind      <= k;
			lexeme_length   <= t.cnt[4:0];
			lexeme_overflow <= t.ovf;
			last            <= fin;
			for (int i = 0; i < 8; i++)
				lexeme_text[8*i +: 8] <= (t.cnt > TOK_CNT_W'(i)) ? t.text[i] : 8'h00;
		end
	end

endmodule

[tb/tb_top.sv]
// self-checking testbench for spec_language_lexer with a token predictor and scoreboard
`timescale 1ns / 1ps

module tb_top;
	import slx_pkg::*;

	localparam int LEX_MAX = 16;
	localparam int CYCLE_LIMIT = 300000;

	typedef enum logic [2:0] {
		LX_IDLE, LX_PAIR, LX_SLASH, LX_WORD, LX_WORD_OPEN, LX_COMMENT, LX_STAR, LX_SKIP
	} lex_mode_e;

	typedef struct {
		logic [5:0]  kind;
		logic [4:0]  len;
		logic [63:0] text;
		logic        ovf;
		logic        last;
	} token_s;

	typedef struct {
		logic [7:0] ch;
		logic       eoi;
	} char_word_s;

	class token_scoreboard;
		logic [7:0] word_buf [LEX_MAX];
		int unsigned word_len;
		lex_mode_e mode;
		logic word_trunc;
		token_s pending_tokens [$];
		token_s step_tokens [$];
		int errors;
		string keywords [30] = '{"in", "isvalid", "and", "or", "crash", "cast", "NULL",
			"partition", "many", "set", "structure", "reserved", "label", "int", "short",
			"bit", "byte", "subtype", "of", "element", "forall", "for", "sizeof", "literal",
			"param", "1", "true", "to", "delay", "static"};

		function new();
			word_len = 0;
			mode = LX_IDLE;
			word_trunc = 0;
			errors = 0;
		endfunction

		function bit is_separator(logic [7:0] c);
			case (c)
				CH_SPACE, CH_BAR, CH_MINUS, CH_PLUS, CH_STAR, CH_SLASH, CH_RBRACK, CH_RPAREN,
				CH_SEMI, CH_COLON, CH_RBRACE, CH_LBRACK, CH_LPAREN, CH_LBRACE, CH_LT, CH_EQ,
				CH_NL, CH_GT, CH_DOT, CH_COMMA: return 1;
				default: return 0;
			endcase
		endfunction

		function logic [5:0] punct_kind(logic [7:0] c, output bit hit);
			hit = 1;
			case (c)
				CH_LBRACK: return KIND_LBRACK;
				CH_RBRACK: return KIND_RBRACK;
				CH_LBRACE: return KIND_LBRACE;
				CH_RBRACE: return KIND_RBRACE;
				CH_LPAREN: return KIND_LPAREN;
				CH_RPAREN: return KIND_RPAREN;
				CH_COMMA: return KIND_COMMA;
				CH_SEMI: return KIND_SEMI;
				CH_COLON: return KIND_COLON;
				CH_BAR: return KIND_BAR;
				CH_BANG: return KIND_BANG;
				CH_PLUS: return KIND_PLUS;
				CH_STAR: return KIND_STAR;
				CH_NL: return KIND_EOL;
				default: begin
					hit = 0;
					return KIND_IDENT;
				end
			endcase
		endfunction

		function bit pair_lookup(logic [7:0] c, output logic [7:0] second,
				output logic [5:0] one, output logic [5:0] two);
			pair_lookup = 1;
			case (c)
				CH_EQ: begin second = CH_GT; one = KIND_EQ; two = KIND_IMPLIES; end
				CH_LT: begin second = CH_EQ; one = KIND_LT; two = KIND_LE; end
				CH_GT: begin second = CH_EQ; one = KIND_GT; two = KIND_GE; end
				CH_DOT: begin second = CH_TILDE; one = KIND_DOT; two = KIND_DOTTIL; end
				CH_MINUS: begin second = CH_GT; one = KIND_MINUS; two = KIND_ARROW; end
				default: begin second = 0; one = 0; two = 0; pair_lookup = 0; end
			endcase
		endfunction

		function void emit(logic [5:0] kind, int unsigned len, logic [63:0] text, logic ovf);
			token_s t;
			if (step_tokens.size() >= 2)
				return;
			t.kind = kind;
			t.len = len[4:0];
			t.text = text;
			t.ovf = ovf;
			t.last = 0;
			step_tokens.push_back(t);
		endfunction

		function void append_char(logic [7:0] c);
			if (word_len < LEX_MAX) begin
				word_buf[word_len] = c;
				word_len++;
			end else
				word_trunc = 1;
		endfunction

		function void emit_word();
			logic [63:0] text = '0;
			logic [5:0] kind = KIND_IDENT;
			bit match;
			for (int i = 0; i < word_len && i < 8; i++)
				text[8*i +: 8] = word_buf[i];
			if (!word_trunc)
				for (int i = 0; i < 30; i++)
					if (kind == KIND_IDENT && keywords[i].len() == word_len) begin
						match = 1;
						for (int j = 0; j < word_len; j++)
							if (keywords[i][j] != word_buf[j])
								match = 0;
						if (match)
							kind = KIND_KW_BASE + i[5:0];
					end
			emit(kind, word_len, text, word_trunc);
			word_len = 0;
			word_trunc = 0;
		endfunction

		function void note_input(logic [7:0] c, logic eoi);
			bit again = 1;
			int guard = 0;
			bit hit;
			logic [7:0] second, first;
			logic [5:0] one, two, k;
			step_tokens.delete();
			while (again && guard < 4) begin
				again = 0;
				guard++;
				case (mode)
					LX_IDLE: begin
						k = punct_kind(c, hit);
						if (eoi)
							emit(KIND_EOF, 0, 0, 0);
						else if (c == CH_SPACE || c == CH_TAB) begin
						end else if (c == CH_SLASH) begin
							word_len = 0;
							mode = LX_SLASH;
						end else if (pair_lookup(c, second, one, two)) begin
							word_buf[0] = c;
							word_len = 1;
							mode = LX_PAIR;
						end else if (hit)
							emit(k, 1, {56'd0, c}, 0);
						else begin
							word_buf[0] = c;
							word_len = 1;
							word_trunc = 0;
							mode = LX_WORD;
						end
					end
					LX_PAIR: begin
						first = word_buf[0];
						void'(pair_lookup(first, second, one, two));
						word_len = 0;
						mode = LX_IDLE;
						if (!eoi && c == second)
							emit(two, 2, {48'd0, c, first}, 0);
						else begin
							emit(one, 1, {56'd0, first}, 0);
							again = 1;
						end
					end
					LX_SLASH: begin
						if (!eoi && c == CH_STAR)
							mode = LX_COMMENT;
						else if (word_len == 0) begin
							emit(KIND_DIV, 1, {56'd0, CH_SLASH}, 0);
							mode = LX_IDLE;
							again = 1;
						end else begin
							append_char(CH_SLASH);
							mode = LX_WORD;
							again = 1;
						end
					end
					LX_WORD: begin
						if (eoi) begin
							emit_word();
							emit(KIND_EOF, 0, 0, 0);
							mode = LX_IDLE;
						end else if (is_separator(c)) begin
							emit_word();
							mode = LX_IDLE;
							again = 1;
						end else if (c == CH_TAB)
							mode = LX_WORD_OPEN;
						else
							append_char(c);
					end
					LX_WORD_OPEN: begin
						if (eoi) begin
							emit_word();
							emit(KIND_EOF, 0, 0, 0);
							mode = LX_IDLE;
						end else if (c == CH_SPACE || c == CH_TAB) begin
						end else if (c == CH_SLASH)
							mode = LX_SLASH;
						else begin
							append_char(c);
							mode = LX_WORD;
						end
					end
					LX_COMMENT, LX_STAR: begin
						if (eoi) begin
							emit(KIND_ERROR, 0, 0, 0);
							emit(KIND_EOF, 0, 0, 0);
							word_len = 0;
							word_trunc = 0;
							mode = LX_IDLE;
						end else if (c == CH_STAR)
							mode = LX_STAR;
						else if (c == CH_SLASH && mode == LX_STAR)
							mode = LX_SKIP;
						else if (c != CH_SLASH)
							mode = LX_COMMENT;
					end
					default: begin
						mode = (word_len > 0) ? LX_WORD_OPEN : LX_IDLE;
						if (eoi)
							again = 1;
					end
				endcase
			end
			if (step_tokens.size() > 0)
				step_tokens[step_tokens.size() - 1].last = 1;
			foreach (step_tokens[i])
				pending_tokens.push_back(step_tokens[i]);
		endfunction

		function void check_token(logic [5:0] kind, logic [4:0] len, logic [63:0] text,
				logic ovf, logic last);
			token_s e;
			if (pending_tokens.size() == 0) begin
				$error("token with none expected: kind %0d", kind);
				errors++;
				return;
			end
			e = pending_tokens.pop_front();
			if (kind !== e.kind) begin
				$error("token_kind exp %0d got %0d", e.kind, kind);
				errors++;
			end
			if (len !== e.len) begin
				$error("lexeme_length exp %0d got %0d", e.len, len);
				errors++;
			end
			if (text !== e.text) begin
				$error("lexeme_text exp %h got %h", e.text, text);
				errors++;
			end
			if (ovf !== e.ovf) begin
				$error("lexeme_overflow exp %0d got %0d", e.ovf, ovf);
				errors++;
			end
			if (last !== e.last) begin
				$error("last exp %0d got %0d", e.last, last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [7:0] char_in = 0;
	logic end_of_input = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [5:0] token_kind;
	logic [4:0] lexeme_length;
	logic [63:0] lexeme_text;
	logic lexeme_overflow;
	logic last;

	token_scoreboard sb = new();
	char_word_s stream [$];
	int cycles = 0;
	int sent = 0;
	bit no_idle = 0;
	bit hold_go = 0;
	bit stim_done = 0;

	spec_language_lexer uut (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
		if (arst_n && in_valid && in_ready)
			sb.note_input(char_in, end_of_input);
		if (arst_n && out_valid && out_ready)
			sb.check_token(token_kind, lexeme_length, lexeme_text, lexeme_overflow, last);
	end

	function int pick_gap();
		int r = $urandom_range(99);
		if (no_idle || r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(3, 1);
		return $urandom_range(30, 8);
	endfunction

	function void add_char(logic [7:0] c);
		char_word_s w;
		w.ch = c;
		w.eoi = 0;
		stream.push_back(w);
	endfunction

	function void add_eoi();
		char_word_s w;
		w.ch = 8'($urandom_range(255));
		w.eoi = 1;
		stream.push_back(w);
	endfunction

	function void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_char(s[i]);
	endfunction

	function logic [7:0] word_char();
		string pool = "abcdeiloprstuyNL1_9";
		return pool[$urandom_range(pool.len() - 1)];
	endfunction

	function void add_fragment();
		string seps = " |-+*/]);:}[({<=\n>.,";
		string puncts = "[]{}(),;:|!+*\n=<>.-~/";
		string kws [30] = sb.keywords;
		int n;
		case ($urandom_range(11))
			0, 1, 2: begin
				add_text(kws[$urandom_range(29)]);
				add_char(seps[$urandom_range(seps.len() - 1)]);
			end
			3, 4: begin
				n = $urandom_range(6, 1);
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(7) == 0)
						add_char(CH_TAB);
					add_char(word_char());
				end
				add_char(seps[$urandom_range(seps.len() - 1)]);
			end
			5, 6: begin
				add_char(puncts[$urandom_range(puncts.len() - 1)]);
				if ($urandom_range(1))
					add_char(puncts[$urandom_range(puncts.len() - 1)]);
			end
			7: begin
				add_text("/*");
				n = $urandom_range(4);
				for (int i = 0; i < n; i++)
					add_char($urandom_range(3) == 0 ? CH_STAR : word_char());
				if ($urandom_range(5) == 0)
					add_eoi();
				else
					add_text("*/ ");
			end
			8: begin
				n = $urandom_range(24, 15);
				for (int i = 0; i < n; i++)
					add_char(word_char());
				if ($urandom_range(1))
					add_eoi();
				else
					add_char(CH_SPACE);
			end
			9: begin
				add_char(8'($urandom_range(255)));
				add_char(8'($urandom_range(255)));
			end
			10: add_text($urandom_range(1) ? " " : "\t");
			default: if ($urandom_range(2) == 0) add_eoi(); else add_char(CH_NL);
		endcase
	endfunction

	task automatic send_word(char_word_s w);
		int gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		char_in <= w.ch;
		end_of_input <= w.eoi;
		do @(posedge clk); while (in_ready !== 1'b1);
		sent++;
		@(negedge clk);
	endtask

	initial begin
		int gap;
		@(negedge clk);
		forever begin
			if (hold_go) begin
				hold_go = 0;
				out_ready <= 0;
				repeat (80) @(negedge clk);
			end
			gap = pick_gap();
			if (gap > 0) begin
				out_ready <= 0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1;
			@(negedge clk);
		end
	end

	initial begin
		int waited = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);
		add_text("in=>.~<=>=->a\t/**/b/*");
		add_eoi();
		add_eoi();
		while (stream.size() > 0)
			send_word(stream.pop_front());
		while (sent < 425) begin
			add_fragment();
			while (stream.size() > 0) begin
				if (sent == 200)
					hold_go = 1;
				no_idle = (sent >= 320 && sent < 400);
				send_word(stream.pop_front());
			end
		end
		in_valid <= 0;
		while (sb.pending_tokens.size() > 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending_tokens.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[spec_language_lexer.f]
rtl/slx_pkg.sv
rtl/slx_front.sv
rtl/slx_fifo.sv
rtl/slx_back.sv
rtl/spec_language_lexer.sv
tb/tb_top.sv
